[rtl/stt_pkg.sv]
// shared types, token codes and keyword table for the source text tokenizer
// no dependencies
`default_nettype none

package stt_pkg;

  localparam int POSITION_WIDTH_DEF = 24;
  localparam int QUEUE_DEPTH_DEF    = 4;
  localparam int KW_MAX_CHARS       = 8;
  localparam int KW_COUNT           = 51;
  localparam int FIELD_W            = 24;
  localparam int MAX_TOKENS         = 3;
  localparam logic [FIELD_W-1:0] LINE_MAX = '1;

  localparam logic [6:0] K_COLON = 7'd0, K_LPAREN = 7'd1, K_RPAREN = 7'd2,
    K_LBRACE = 7'd3, K_RBRACE = 7'd4, K_LSQ = 7'd5, K_RSQ = 7'd6,
    K_DOLLAR_LBRACE = 7'd7, K_DOLLAR_LSQ = 7'd8, K_SEMI = 7'd9, K_COMMA = 7'd10,
    K_DOTDOT = 7'd11, K_DOT = 7'd12, K_ARROW = 7'd13, K_MINUS_EQ = 7'd14,
    K_MINUS = 7'd15, K_PLUS_EQ = 7'd16, K_PLUS = 7'd17, K_SLASH_EQ = 7'd18,
    K_SLASH = 7'd19, K_BSLASH_EQ = 7'd20, K_BSLASH = 7'd21, K_STARSTAR = 7'd22,
    K_STAR_EQ = 7'd23, K_STAR = 7'd24, K_PERCENT_EQ = 7'd25, K_PERCENT = 7'd26,
    K_BANG_EQ = 7'd27, K_EQEQ = 7'd28, K_EQ_ARROW = 7'd29, K_EQ = 7'd30,
    K_SHL = 7'd31, K_LESS_EQ = 7'd32, K_LESS = 7'd33, K_SHR = 7'd34,
    K_GREATER_EQ = 7'd35, K_GREATER = 7'd36, K_QUESTION = 7'd37, K_AMP = 7'd38,
    K_PIPE = 7'd39, K_CARET = 7'd40, K_TILDE = 7'd41, K_KW_BASE = 7'd42,
    K_STRING = 7'd93, K_INT = 7'd94, K_FLOAT = 7'd95, K_IDENT = 7'd96,
    K_ERROR = 7'd97, K_END = 7'd98;

  localparam logic [1:0] ERR_NONE = 2'd0, ERR_UNTERMINATED = 2'd1,
    ERR_UNEXPECTED_TOKEN = 2'd2, ERR_UNEXPECTED_CHAR = 2'd3;

  // first character in the most significant used byte
  localparam logic [8*KW_MAX_CHARS-1:0] KW_TEXT [KW_COUNT] = '{
    "Nil", "Never", "Bool", "Buffer", "Int", "File", "Float", "Complex",
    "String", "Set", "Tuple", "Table", "Range", "Random", "Result", "Any",
    "Array", "Vector", "Matrix",
    "as", "and", "break", "continue", "dynuse", "default", "else", "give",
    "impl", "if", "let", "not", "nil", "new", "or", "return", "struct",
    "shape", "while", "false", "for", "fn", "from", "match", "true", "type",
    "typeof", "use", "panic", "pub", "Err", "Ok"
  };

  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_source;
  } item_t;

  typedef struct packed {
    logic [6:0]         token_kind;
    logic [FIELD_W-1:0] token_start;
    logic [FIELD_W-1:0] token_length;
    logic [FIELD_W-1:0] token_line;
    logic [1:0]         error_kind;
    logic               last_of_run;
  } token_t;

  typedef struct packed {
    token_t [MAX_TOKENS-1:0] tok;
    logic [1:0]              count;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic [6:0] kw_kind(input logic [8*KW_MAX_CHARS-1:0] word);
    logic [6:0] k;
    k = K_IDENT;
    for (int i = 0; i < KW_COUNT; i++) begin
      if (word == KW_TEXT[i]) k = 7'(int'(K_KW_BASE) + i);
    end
    return k;
  endfunction

endpackage

`default_nettype wire

[rtl/stt_front.sv]
// scanner front end: one byte per request, builds a bundle of up to three tokens
// depends on stt_pkg
`default_nettype none

module stt_front import stt_pkg::*; #(
  parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic take,
  input  wire item_t item,
  output bundle_t   bundle,
  output logic      bundle_push
);

  localparam int P = POSITION_WIDTH;
  localparam logic [P-1:0] POS_MAX = '1;
  localparam int KW_W = 8 * KW_MAX_CHARS;

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_INT, M_INT_DOT, M_FLOAT, M_OP,
    M_DSTR, M_SSTR, M_DESC, M_SESC, M_COMMENT
  } mode_t;

  typedef struct packed {
    mode_t      mode;
    logic       lex;
    logic       hit;
    logic [6:0] kind;
    logic [1:0] err;
    logic       newline;
  } idle_t;

  typedef struct packed {
    logic       hit;
    logic [6:0] kind;
  } pair_t;

  typedef struct packed {
    logic [6:0] kind;
    logic [1:0] err;
  } single_t;

  mode_t         mode, mode_next;
  logic [7:0]    held, held_next;
  logic [P-1:0]  lstart, lstart_next;
  logic [P-1:0]  bpos, bpos_next;
  logic [FIELD_W-1:0] line, line_next;
  logic [KW_W-1:0] kw, kw_next;
  logic [P-1:0]  llen, llen_next;

  token_t [MAX_TOKENS-1:0] tok;
  logic [1:0]    n;
  logic          do_idle;
  idle_t         idl;
  pair_t         pr;
  single_t       sg;
  logic [6:0]    ident_kind;
  logic [P-1:0]  dot_pos, llen_inc, llen_add2;
  logic [FIELD_W-1:0] line_inc;
  logic [7:0]    c;

  function automatic logic [P-1:0] sat_inc(input logic [P-1:0] x);
    return (x == POS_MAX) ? x : x + P'(1);
  endfunction

  function automatic logic [P-1:0] sat_add(input logic [P-1:0] a, input logic [P-1:0] b);
    logic [P:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[P] ? POS_MAX : s[P-1:0];
  endfunction

  function automatic logic num_char(input logic [7:0] ch);
    return ch >= "0" && ch <= "9";
  endfunction

  function automatic logic alpha_char(input logic [7:0] ch);
    return (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z") || ch == "_";
  endfunction

  function automatic logic [FIELD_W-1:0] to_field(input logic [P-1:0] x);
    return FIELD_W'(32'(x));
  endfunction

  function automatic idle_t idle_scan(input logic [7:0] ch);
    idle_t r;
    r = '{mode: M_IDLE, lex: 1'b0, hit: 1'b0, kind: K_ERROR, err: ERR_NONE,
          newline: 1'b0};
    if (num_char(ch)) begin
      r.lex = 1'b1; r.mode = M_INT;
    end else if (alpha_char(ch)) begin
      r.lex = 1'b1; r.mode = M_IDENT;
    end else begin
      unique case (ch)
        " ", "\t", 8'h0D: ;
        "\n": r.newline = 1'b1;
        ":": begin r.hit = 1'b1; r.kind = K_COLON; end
        "(": begin r.hit = 1'b1; r.kind = K_LPAREN; end
        ")": begin r.hit = 1'b1; r.kind = K_RPAREN; end
        "{": begin r.hit = 1'b1; r.kind = K_LBRACE; end
        "}": begin r.hit = 1'b1; r.kind = K_RBRACE; end
        "[": begin r.hit = 1'b1; r.kind = K_LSQ; end
        "]": begin r.hit = 1'b1; r.kind = K_RSQ; end
        ";": begin r.hit = 1'b1; r.kind = K_SEMI; end
        ",": begin r.hit = 1'b1; r.kind = K_COMMA; end
        "?": begin r.hit = 1'b1; r.kind = K_QUESTION; end
        "&": begin r.hit = 1'b1; r.kind = K_AMP; end
        "|": begin r.hit = 1'b1; r.kind = K_PIPE; end
        "^": begin r.hit = 1'b1; r.kind = K_CARET; end
        "~": begin r.hit = 1'b1; r.kind = K_TILDE; end
        "$", ".", "-", "+", "/", "\\", "*", "%", "!", "=", "<", ">": begin
          r.lex = 1'b1; r.mode = M_OP;
        end
        "\"": begin r.lex = 1'b1; r.mode = M_DSTR; end
        "'": begin r.lex = 1'b1; r.mode = M_SSTR; end
        default: begin r.hit = 1'b1; r.kind = K_ERROR; r.err = ERR_UNEXPECTED_CHAR; end
      endcase
    end
    return r;
  endfunction

  function automatic single_t single_kind(input logic [7:0] h);
    single_t r;
    r = '{kind: K_ERROR, err: ERR_NONE};
    unique case (h)
      ".": r.kind = K_DOT;
      "-": r.kind = K_MINUS;
      "+": r.kind = K_PLUS;
      "/": r.kind = K_SLASH;
      "\\": r.kind = K_BSLASH;
      "*": r.kind = K_STAR;
      "%": r.kind = K_PERCENT;
      "=": r.kind = K_EQ;
      "<": r.kind = K_LESS;
      ">": r.kind = K_GREATER;
      default: r.err = ERR_UNEXPECTED_TOKEN;
    endcase
    return r;
  endfunction

  function automatic pair_t pair_kind(input logic [7:0] h, input logic [7:0] ch);
    pair_t r;
    r = '{hit: 1'b0, kind: K_ERROR};
    unique case (h)
      ".":  if (ch == ".") r = '{1'b1, K_DOTDOT};
      "-":  if (ch == ">") r = '{1'b1, K_ARROW};
            else if (ch == "=") r = '{1'b1, K_MINUS_EQ};
      "+":  if (ch == "=") r = '{1'b1, K_PLUS_EQ};
      "/":  if (ch == "=") r = '{1'b1, K_SLASH_EQ};
      "\\": if (ch == "=") r = '{1'b1, K_BSLASH_EQ};
      "*":  if (ch == "*") r = '{1'b1, K_STARSTAR};
            else if (ch == "=") r = '{1'b1, K_STAR_EQ};
      "%":  if (ch == "=") r = '{1'b1, K_PERCENT_EQ};
      "!":  if (ch == "=") r = '{1'b1, K_BANG_EQ};
      "=":  if (ch == "=") r = '{1'b1, K_EQEQ};
            else if (ch == ">") r = '{1'b1, K_EQ_ARROW};
      "<":  if (ch == "<") r = '{1'b1, K_SHL};
            else if (ch == "=") r = '{1'b1, K_LESS_EQ};
      ">":  if (ch == ">") r = '{1'b1, K_SHR};
            else if (ch == "=") r = '{1'b1, K_GREATER_EQ};
      "$":  if (ch == "{") r = '{1'b1, K_DOLLAR_LBRACE};
            else if (ch == "[") r = '{1'b1, K_DOLLAR_LSQ};
      default: ;
    endcase
    return r;
  endfunction

  function automatic token_t mk(input logic [6:0] k, input logic [P-1:0] s,
                                input logic [P-1:0] l, input logic [1:0] e,
                                input logic [FIELD_W-1:0] ln);
    token_t t;
    t.token_kind   = k;
    t.token_start  = to_field(s);
    t.token_length = to_field(l);
    t.token_line   = ln;
    t.error_kind   = e;
    t.last_of_run  = 1'b0;
    return t;
  endfunction

  assign c = item.source_byte;

  always_comb begin
    tok = '0;
    n = 2'd0;
    do_idle = 1'b0;
    mode_next = mode; held_next = held; lstart_next = lstart; bpos_next = bpos;
    line_next = line; kw_next = kw; llen_next = llen;
    idl = idle_scan(c);
    pr = pair_kind(held, c);
    sg = single_kind(held);
    ident_kind = (llen > P'(KW_MAX_CHARS)) ? K_IDENT : kw_kind(kw);
    dot_pos = sat_add(lstart, llen);
    llen_inc = sat_inc(llen);
    llen_add2 = sat_add(llen, P'(2));
    line_inc = (line == LINE_MAX) ? line : line + FIELD_W'(1);

    if (item.end_of_source) begin
      unique case (mode)
        M_IDENT: begin tok[n] = mk(ident_kind, lstart, llen, ERR_NONE, line); n = n + 2'd1; end
        M_INT:   begin tok[n] = mk(K_INT, lstart, llen, ERR_NONE, line); n = n + 2'd1; end
        M_FLOAT: begin tok[n] = mk(K_FLOAT, lstart, llen, ERR_NONE, line); n = n + 2'd1; end
        M_INT_DOT: begin
          tok[n] = mk(K_INT, lstart, llen, ERR_NONE, line); n = n + 2'd1;
          tok[n] = mk(K_DOT, dot_pos, P'(1), ERR_NONE, line); n = n + 2'd1;
        end
        M_OP: begin tok[n] = mk(sg.kind, lstart, P'(1), sg.err, line); n = n + 2'd1; end
        M_DSTR, M_SSTR, M_DESC, M_SESC: begin
          tok[n] = mk(K_ERROR, lstart, llen, ERR_UNTERMINATED, line); n = n + 2'd1;
        end
        default: ;
      endcase
      tok[n] = mk(K_END, bpos, '0, ERR_NONE, line); n = n + 2'd1;
      mode_next = M_IDLE;
    end else begin
      unique case (mode)
        M_IDENT: begin
          if (alpha_char(c) || num_char(c)) begin
            if (llen < P'(KW_MAX_CHARS)) kw_next = {kw[KW_W-9:0], c};
            llen_next = llen_inc;
          end else begin
            tok[n] = mk(ident_kind, lstart, llen, ERR_NONE, line); n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        M_INT: begin
          if (num_char(c)) llen_next = llen_inc;
          else if (c == ".") mode_next = M_INT_DOT;
          else begin
            tok[n] = mk(K_INT, lstart, llen, ERR_NONE, line); n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        M_INT_DOT: begin
          if (num_char(c)) begin
            llen_next = llen_add2;
            mode_next = M_FLOAT;
          end else begin
            tok[n] = mk(K_INT, lstart, llen, ERR_NONE, line); n = n + 2'd1;
            mode_next = M_IDLE;
            if (c == ".") begin
              tok[n] = mk(K_DOTDOT, dot_pos, P'(2), ERR_NONE, line); n = n + 2'd1;
            end else begin
              tok[n] = mk(K_DOT, dot_pos, P'(1), ERR_NONE, line); n = n + 2'd1;
              do_idle = 1'b1;
            end
          end
        end
        M_FLOAT: begin
          if (num_char(c)) llen_next = llen_inc;
          else begin
            tok[n] = mk(K_FLOAT, lstart, llen, ERR_NONE, line); n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        M_OP: begin
          if (held == "/" && c == "/") mode_next = M_COMMENT;
          else if (pr.hit) begin
            tok[n] = mk(pr.kind, lstart, P'(2), ERR_NONE, line); n = n + 2'd1;
            mode_next = M_IDLE;
          end else begin
            tok[n] = mk(sg.kind, lstart, P'(1), sg.err, line); n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        M_DSTR, M_SSTR: begin
          llen_next = llen_inc;
          if (c == ((mode == M_DSTR) ? 8'("\"") : 8'("'"))) begin
            tok[n] = mk(K_STRING, lstart, llen_inc, ERR_NONE, line); n = n + 2'd1;
            mode_next = M_IDLE;
          end else if (c == "\\") begin
            mode_next = (mode == M_DSTR) ? M_DESC : M_SESC;
          end else if (c == "\n") begin
            line_next = line_inc;
          end
        end
        M_DESC, M_SESC: begin
          llen_next = llen_inc;
          mode_next = (mode == M_DESC) ? M_DSTR : M_SSTR;
        end
        M_COMMENT: begin
          if (c == "\n") begin
            line_next = line_inc;
            mode_next = M_IDLE;
          end
        end
        default: do_idle = 1'b1;
      endcase
      if (do_idle) begin
        if (idl.hit) begin
          tok[n] = mk(idl.kind, bpos, P'(1), idl.err, line); n = n + 2'd1;
        end
        mode_next = idl.mode;
        if (idl.lex) begin
          lstart_next = bpos;
          llen_next = P'(1);
          held_next = c;
          kw_next = {{(KW_W-8){1'b0}}, c};
        end
        if (idl.newline) line_next = line_inc;
      end
      bpos_next = sat_inc(bpos);
    end
  end

  assign bundle.tok   = tok;
  assign bundle.count = n;
  assign bundle_push  = take && (n != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      held <= '0;
      lstart <= '0;
      bpos <= '0;
      line <= FIELD_W'(1);
      kw <= '0;
      llen <= '0;
    end else if (take) begin
      mode <= mode_next;
      held <= held_next;
      lstart <= lstart_next;
      bpos <= bpos_next;
      line <= line_next;
      kw <= kw_next;
      llen <= llen_next;
    end
  end

endmodule

`default_nettype wire

[rtl/stt_queue.sv]
// short bundle queue between scanner and token output stage
// depends on stt_pkg
`default_nettype none

module stt_queue import stt_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    wr,
  input  wire bundle_t wdata,
  input  wire logic    rd,
  output bundle_t      rdata,
  output qstat_t       stat
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  bundle_t         mem [DEPTH];
  logic [AW-1:0]   wptr, rptr;
  logic [CW-1:0]   count;

  assign rdata      = mem[rptr];
  assign stat.full  = (count == CW'(DEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (wr) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (wr) wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
      if (rd) rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + AW'(1);
      count <= count + CW'(wr) - CW'(rd);
    end
  end

endmodule

`default_nettype wire

[rtl/stt_back.sv]
// output stage: unpacks one bundle into single tokens, one per pop
// depends on stt_pkg
`default_nettype none

module stt_back import stt_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire qstat_t  qstat,
  input  wire bundle_t qdata,
  output logic         qpop,
  input  wire logic    pop,
  output logic         empty,
  output token_t       token
);

  bundle_t    cur;
  logic [1:0] idx;
  logic       valid;
  logic       last, take;

  assign last  = (idx == cur.count - 2'd1);
  assign take  = pop && valid;
  assign qpop  = !qstat.empty && (!valid || (take && last));
  assign empty = !valid;

  always_comb begin
    token = cur.tok[idx];
    token.last_of_run = last;
  end

  always_ff @(posedge clk) begin
    if (qpop) cur <= qdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx <= '0;
    end else if (qpop) begin
      valid <= 1'b1;
      idx <= '0;
    end else if (take) begin
      if (last) valid <= 1'b0;
      else idx <= idx + 2'd1;
    end
  end

endmodule

`default_nettype wire

[rtl/source_text_tokenizer.sv]
// top level of the source text tokenizer
// depends on stt_pkg, stt_front, stt_queue, stt_back
//
// Source bytes enter one per cycle while full is low and are scanned at once;
// each byte yields zero to three tokens, which are grouped and held in a queue
// of QUEUE_DEPTH groups. Tokens leave one per cycle at the output side while pop
// is held, so a byte that closes two or three tokens needs as many pops to drain,
// while bytes go on entering until the queue fills. full is the queue's full
// flag. All scanner state registers loop, not the mode alone; the keyword
// match runs in the same cycle as the byte that ends the identifier.
`default_nettype none

module source_text_tokenizer import stt_pkg::*; #(
  parameter int POSITION_WIDTH = POSITION_WIDTH_DEF,
  parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  output logic       full,
  input  wire item_t item,
  output logic       empty,
  input  wire logic  pop,
  output token_t     token
);

  bundle_t fbundle, qdata;
  logic    fpush, qpop, take;
  qstat_t  qstat;

  assign full = qstat.full;
  assign take = push && !qstat.full;

  stt_front #(.POSITION_WIDTH(POSITION_WIDTH)) u_front (
    .clk, .rst, .take, .item, .bundle(fbundle), .bundle_push(fpush)
  );

  stt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst, .wr(fpush), .wdata(fbundle), .rd(qpop), .rdata(qdata), .stat(qstat)
  );

  stt_back u_back (
    .clk, .rst, .qstat, .qdata, .qpop, .pop, .empty, .token
  );

endmodule

`default_nettype wire

[rtl/stt_checker.sv]
// port-level checks for the source text tokenizer, bound to the top level
// depends on stt_pkg
`default_nettype none

module stt_checker import stt_pkg::*; (
  input wire logic   clk,
  input wire logic   rst,
  input wire logic   push,
  input wire logic   full,
  input wire item_t  item,
  input wire logic   empty,
  input wire logic   pop,
  input wire token_t token
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("output not empty after reset");

  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    !empty |-> token.token_line != '0)
    else $error("token line is zero");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> token.token_kind <= K_END)
    else $error("token kind out of range");

  a_err_kind: assert property (@(posedge clk) disable iff (rst)
    (!empty && token.error_kind != ERR_NONE) |-> token.token_kind == K_ERROR)
    else $error("error code on non-error token");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(token)))
    else $error("waiting token changed");

endmodule

bind source_text_tokenizer stt_checker u_chk (.*);

`default_nettype wire

[dv/tb_source_text_tokenizer.sv]
// self-checking testbench for source_text_tokenizer: bytes in, tokens out
// predicts tokens with its own scanner model; depends on stt_pkg and the rtl
`timescale 1ns / 100ps

module tb_source_text_tokenizer;
  import stt_pkg::*;

  typedef enum {
    SC_IDLE, SC_IDENT, SC_INT, SC_INT_DOT, SC_FLOAT, SC_OP,
    SC_DSTR, SC_SSTR, SC_DESC, SC_SESC, SC_COMMENT
  } scan_state_t;

  localparam logic [6:0] NO_PAIR = 7'h7F;
  localparam logic [23:0] POS_TOP = '1;
  localparam int IDLE_LIMIT = 3000;

  logic clk = 0;
  logic rst = 1;
  logic push = 0;
  logic pop = 0;
  item_t item = '0;
  logic full, empty;
  token_t token;

  source_text_tokenizer dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .token(token)
  );

  always #4 clk = ~clk;

  // scanner state of the predictor
  scan_state_t sc_mode;
  logic [7:0] sc_held;
  logic [23:0] sc_start, sc_pos, sc_line, sc_len;
  logic [63:0] sc_word;
  token_t token_q[$];
  int errors = 0;
  int burst_left = 0;
  bit hold_go = 0;
  int hold_left = 0;
  int rx_mode = 0;
  int rx_cycle = 0;
  int idle_cycles = 0;

  function automatic logic [23:0] sat_inc(logic [23:0] x);
    return (x == POS_TOP) ? x : x + 24'd1;
  endfunction

  function automatic logic [23:0] sat_add(logic [23:0] a, logic [23:0] b);
    logic [24:0] s;
    s = a + b;
    return s[24] ? POS_TOP : s[23:0];
  endfunction

  function automatic bit num_char(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit alpha_char(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic void add_token(logic [6:0] kind, logic [23:0] start,
                                    logic [23:0] len, logic [1:0] err);
    token_t t;
    t.token_kind = kind;
    t.token_start = start;
    t.token_length = len;
    t.token_line = sc_line;
    t.error_kind = err;
    t.last_of_run = 1'b0;
    token_q.push_back(t);
  endfunction

  function automatic logic [6:0] word_kind();
    logic [6:0] k;
    k = K_IDENT;
    if (sc_len <= KW_MAX_CHARS)
      for (int i = 0; i < KW_COUNT; i++)
        if (KW_TEXT[i] == sc_word) k = K_KW_BASE + 7'(i);
    return k;
  endfunction

  function automatic logic [6:0] lone_op(logic [7:0] h);
    case (h)
      ".": return K_DOT;
      "-": return K_MINUS;
      "+": return K_PLUS;
      "/": return K_SLASH;
      "\\": return K_BSLASH;
      "*": return K_STAR;
      "%": return K_PERCENT;
      "=": return K_EQ;
      "<": return K_LESS;
      ">": return K_GREATER;
      default: return K_ERROR;
    endcase
  endfunction

  function automatic void emit_lone_op();
    logic [6:0] k;
    k = lone_op(sc_held);
    add_token(k, sc_start, 24'd1, (k == K_ERROR) ? ERR_UNEXPECTED_TOKEN : ERR_NONE);
  endfunction

  function automatic logic [6:0] op_pair(logic [7:0] h, logic [7:0] c);
    case (h)
      ".": return c == "." ? K_DOTDOT : NO_PAIR;
      "-": return c == ">" ? K_ARROW : (c == "=" ? K_MINUS_EQ : NO_PAIR);
      "+": return c == "=" ? K_PLUS_EQ : NO_PAIR;
      "/": return c == "=" ? K_SLASH_EQ : NO_PAIR;
      "\\": return c == "=" ? K_BSLASH_EQ : NO_PAIR;
      "*": return c == "*" ? K_STARSTAR : (c == "=" ? K_STAR_EQ : NO_PAIR);
      "%": return c == "=" ? K_PERCENT_EQ : NO_PAIR;
      "!": return c == "=" ? K_BANG_EQ : NO_PAIR;
      "=": return c == "=" ? K_EQEQ : (c == ">" ? K_EQ_ARROW : NO_PAIR);
      "<": return c == "<" ? K_SHL : (c == "=" ? K_LESS_EQ : NO_PAIR);
      ">": return c == ">" ? K_SHR : (c == "=" ? K_GREATER_EQ : NO_PAIR);
      "$": return c == "{" ? K_DOLLAR_LBRACE : (c == "[" ? K_DOLLAR_LSQ : NO_PAIR);
      default: return NO_PAIR;
    endcase
  endfunction

  function automatic void open_lexeme(logic [23:0] p, scan_state_t m);
    sc_start = p;
    sc_len = 24'd1;
    sc_mode = m;
  endfunction

  function automatic void scan_fresh(logic [7:0] c, logic [23:0] p);
    sc_mode = SC_IDLE;
    if (num_char(c)) open_lexeme(p, SC_INT);
    else if (alpha_char(c)) begin
      open_lexeme(p, SC_IDENT);
      sc_word = 64'(c);
    end else begin
      case (c)
        " ", 8'h0D, "\t": ;
        "\n": if (sc_line != LINE_MAX) sc_line++;
        ":": add_token(K_COLON, p, 24'd1, ERR_NONE);
        "(": add_token(K_LPAREN, p, 24'd1, ERR_NONE);
        ")": add_token(K_RPAREN, p, 24'd1, ERR_NONE);
        "{": add_token(K_LBRACE, p, 24'd1, ERR_NONE);
        "}": add_token(K_RBRACE, p, 24'd1, ERR_NONE);
        "[": add_token(K_LSQ, p, 24'd1, ERR_NONE);
        "]": add_token(K_RSQ, p, 24'd1, ERR_NONE);
        ";": add_token(K_SEMI, p, 24'd1, ERR_NONE);
        ",": add_token(K_COMMA, p, 24'd1, ERR_NONE);
        "?": add_token(K_QUESTION, p, 24'd1, ERR_NONE);
        "&": add_token(K_AMP, p, 24'd1, ERR_NONE);
        "|": add_token(K_PIPE, p, 24'd1, ERR_NONE);
        "^": add_token(K_CARET, p, 24'd1, ERR_NONE);
        "~": add_token(K_TILDE, p, 24'd1, ERR_NONE);
        "$", ".", "-", "+", "/", "\\", "*", "%", "!", "=", "<", ">": begin
          open_lexeme(p, SC_OP);
          sc_held = c;
        end
        "\"": open_lexeme(p, SC_DSTR);
        "'": open_lexeme(p, SC_SSTR);
        default: add_token(K_ERROR, p, 24'd1, ERR_UNEXPECTED_CHAR);
      endcase
    end
  endfunction

  function automatic void predict_tokens(item_t it);
    logic [7:0] c;
    logic [23:0] p;
    logic [6:0] k;
    int n0;
    c = it.source_byte;
    p = sc_pos;
    n0 = token_q.size();
    if (it.end_of_source) begin
      case (sc_mode)
        SC_IDENT: add_token(word_kind(), sc_start, sc_len, ERR_NONE);
        SC_INT: add_token(K_INT, sc_start, sc_len, ERR_NONE);
        SC_FLOAT: add_token(K_FLOAT, sc_start, sc_len, ERR_NONE);
        SC_INT_DOT: begin
          add_token(K_INT, sc_start, sc_len, ERR_NONE);
          add_token(K_DOT, sat_add(sc_start, sc_len), 24'd1, ERR_NONE);
        end
        SC_OP: emit_lone_op();
        SC_DSTR, SC_SSTR, SC_DESC, SC_SESC:
          add_token(K_ERROR, sc_start, sc_len, ERR_UNTERMINATED);
        default: ;
      endcase
      add_token(K_END, sc_pos, 24'd0, ERR_NONE);
      sc_mode = SC_IDLE;
    end else begin
      case (sc_mode)
        SC_IDLE: scan_fresh(c, p);
        SC_IDENT:
          if (alpha_char(c) || num_char(c)) begin
            if (sc_len < KW_MAX_CHARS) sc_word = {sc_word[55:0], c};
            sc_len = sat_inc(sc_len);
          end else begin
            add_token(word_kind(), sc_start, sc_len, ERR_NONE);
            scan_fresh(c, p);
          end
        SC_INT:
          if (num_char(c)) sc_len = sat_inc(sc_len);
          else if (c == ".") sc_mode = SC_INT_DOT;
          else begin
            add_token(K_INT, sc_start, sc_len, ERR_NONE);
            scan_fresh(c, p);
          end
        SC_INT_DOT:
          if (num_char(c)) begin
            sc_len = sat_add(sc_len, 24'd2);
            sc_mode = SC_FLOAT;
          end else begin
            add_token(K_INT, sc_start, sc_len, ERR_NONE);
            sc_mode = SC_IDLE;
            if (c == ".") add_token(K_DOTDOT, sat_add(sc_start, sc_len), 24'd2, ERR_NONE);
            else begin
              add_token(K_DOT, sat_add(sc_start, sc_len), 24'd1, ERR_NONE);
              scan_fresh(c, p);
            end
          end
        SC_FLOAT:
          if (num_char(c)) sc_len = sat_inc(sc_len);
          else begin
            add_token(K_FLOAT, sc_start, sc_len, ERR_NONE);
            scan_fresh(c, p);
          end
        SC_OP:
          if (sc_held == "/" && c == "/") sc_mode = SC_COMMENT;
          else begin
            k = op_pair(sc_held, c);
            if (k != NO_PAIR) begin
              add_token(k, sc_start, 24'd2, ERR_NONE);
              sc_mode = SC_IDLE;
            end else begin
              emit_lone_op();
              scan_fresh(c, p);
            end
          end
        SC_DSTR, SC_SSTR: begin
          sc_len = sat_inc(sc_len);
          if (c == ((sc_mode == SC_DSTR) ? 8'h22 : 8'h27)) begin
            add_token(K_STRING, sc_start, sc_len, ERR_NONE);
            sc_mode = SC_IDLE;
          end else if (c == "\\") sc_mode = (sc_mode == SC_DSTR) ? SC_DESC : SC_SESC;
          else if (c == "\n" && sc_line != LINE_MAX) sc_line++;
        end
        SC_DESC, SC_SESC: begin
          sc_len = sat_inc(sc_len);
          sc_mode = (sc_mode == SC_DESC) ? SC_DSTR : SC_SSTR;
        end
        SC_COMMENT:
          if (c == "\n") begin
            if (sc_line != LINE_MAX) sc_line++;
            sc_mode = SC_IDLE;
          end
        default: scan_fresh(c, p);
      endcase
      sc_pos = sat_inc(sc_pos);
    end
    if (token_q.size() > n0) token_q[token_q.size()-1].last_of_run = 1'b1;
  endfunction

  // one request, with burst gaps in front of it
  task automatic send_byte(logic [7:0] b, logic eos = 1'b0);
    item_t it;
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 6)) begin
        push <= 1'b0;
        @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    it.source_byte = b;
    it.end_of_source = eos;
    push <= 1'b1;
    item <= it;
    @(negedge clk);
    while (full) @(negedge clk);
    @(posedge clk);
    predict_tokens(it);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_end();
    send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic test_directed();
    send_text("fn iff 1.2 3.. $");
    send_byte(8'h80);
    send_byte(8'h00);
    send_text("!x\n");
    send_end();
    send_text("'a\\\nb");
    send_end();
  endtask

  function automatic string rand_token();
    string ops[43] = '{":", "(", ")", "{", "}", "[", "]", "${", "$[", ";", ",",
      "..", ".", "->", "-=", "-", "+=", "+", "/=", "/", "\\=", "\\", "**", "*=",
      "*", "%=", "%", "!=", "==", "=>", "=", "<<", "<=", "<", ">>", ">=", ">", "?",
      "&", "|", "^", "~", "!"};
    string words[12] = '{"Complex", "continue", "if", "fn", "Ok", "typeof",
      "Matrix", "struct", "Result", "ifx", "fnord", "Vector"};
    string s;
    int n;
    s = "";
    case ($urandom_range(0, 9))
      0, 1, 2: s = ops[$urandom_range(0, 42)];
      3: s = words[$urandom_range(0, 11)];
      4: begin
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(97, 122)))};
      end
      5: begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(48, 57)))};
        case ($urandom_range(0, 3))
          0: s = {s, ".7"};
          1: s = {s, "."};
          2: s = {s, ".."};
          default: ;
        endcase
      end
      6: s = ($urandom_range(0, 1)) ? "\"a\\\"b\nc\"" : "'x\\\ny'";
      7: s = "// q;\n";
      8: s = string'(8'($urandom_range(0, 255)));
      default: s = ($urandom_range(0, 1)) ? "\n" : "\t";
    endcase
    if ($urandom_range(0, 1)) s = {s, " "};
    return s;
  endfunction

  task automatic test_random_text(int n_bytes);
    string s;
    int sent;
    sent = 0;
    while (sent < n_bytes) begin
      s = rand_token();
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
      sent += s.len();
      if ($urandom_range(0, 14) == 0) begin
        send_end();
        sent++;
      end
    end
    send_end();
  endtask

  task automatic test_backpressure();
    hold_go = 1'b1;
    for (int i = 0; i < 20; i++) send_text("$x");
    send_end();
  endtask

  // receiver stall pattern, with a long hold-off during the backpressure test
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_go || hold_left > 0) begin
      if (hold_go) begin
        hold_go = 1'b0;
        hold_left <= 300;
      end else begin
        hold_left <= hold_left - 1;
      end
      pop <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 2);
      case (rx_mode)
        0: pop <= 1'b1;
        1: pop <= ($urandom_range(0, 3) != 0);
        default: pop <= $urandom_range(0, 1);
      endcase
    end
  end

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(negedge clk) begin
    if (!rst && pop && !empty) begin
      if (token_q.size() == 0) begin
        $error("token with none expected: kind %0d", token.token_kind);
        errors++;
      end else begin
        token_t w;
        w = token_q.pop_front();
        check_field("token_kind", w.token_kind, token.token_kind);
        check_field("token_start", w.token_start, token.token_start);
        check_field("token_length", w.token_length, token.token_length);
        check_field("token_line", w.token_line, token.token_line);
        check_field("error_kind", w.error_kind, token.error_kind);
        check_field("last_of_run", w.last_of_run, token.last_of_run);
      end
    end
    if ((push && !full) || (pop && !empty)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("tb_source_text_tokenizer: errors");
      $finish;
    end
  end

  initial begin
    sc_mode = SC_IDLE;
    sc_held = '0;
    sc_start = '0;
    sc_pos = '0;
    sc_line = 24'd1;
    sc_word = '0;
    sc_len = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random_text(200);
    push <= 1'b0;
    while (token_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("tb_source_text_tokenizer: clean");
    else
      $display("tb_source_text_tokenizer: errors");
    $finish;
  end

endmodule

[files.f]
rtl/stt_pkg.sv
rtl/stt_front.sv
rtl/stt_queue.sv
rtl/stt_back.sv
rtl/source_text_tokenizer.sv
rtl/stt_checker.sv
dv/tb_source_text_tokenizer.sv
